/* design/vtsnr_pkg.sv */
package vtsnr_pkg;

	// Field and register widths
	localparam int SAMPLE_BITS    = 16;
	localparam int CUTOFF_BITS    = 16;
	localparam int RC_BITS        = 11;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;
	localparam int OUT_BITS       = 24;

	// Fixed-point scaling: mean in Q16.8, tSNR ratio scaled by 2^16 before the root
	localparam int FRAC_BITS  = 8;
	localparam int TSNR_SHIFT = 16;

	// Volume count limits
	localparam int MAX_REPETITIONS_DEF = 1024;
	localparam int NREP_MIN            = 7;
	localparam int RC_MAX              = (1 << RC_BITS) - 1;
	localparam int FIRST_TAKEN_VOL     = 3;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_CUTOFF_LEVEL     = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REPETITION_COUNT = 1'd1;

	// Reset value of the repetition count register
	localparam logic [RC_BITS-1:0] RC_RESET = 11'd7;

	// Solver sequencer
	typedef enum logic [3:0] {
		SV_IDLE,
		SV_MUL_NQ,
		SV_MUL_SS,
		SV_SUB_D,
		SV_DIV_MEAN,
		SV_MUL_DEN,
		SV_MUL_NUM,
		SV_DIV_TSNR,
		SV_SQRT,
		SV_DONE
	} solve_state_t;

	// End-of-voxel notice from the accumulator to the solver
	typedef struct packed {
		logic start;
		logic in_mask;
	} voxel_end_t;

	// Result flags, in_mask in the low bit
	typedef struct packed {
		logic flat_series;
		logic in_mask;
	} res_flags_t;

	// Largest usable volume count for a given build limit
	function automatic int nrep_top(int max_rep);
		return (max_rep < RC_MAX) ? max_rep : RC_MAX;
	endfunction

	// Bits needed for the count of accumulated samples
	function automatic int count_bits(int max_rep);
		return $clog2((nrep_top(max_rep) - FIRST_TAKEN_VOL) / 2 + 1);
	endfunction

endpackage

/* design/voxel_temporal_snr.sv */
// Temporal SNR of one voxel. Samples of a voxel's time series arrive in volume order,
// one transaction per volume, and are taken at one per cycle: volume 0 decides the mask
// (sample above cutoff_level), and volumes 3, 5, 7 and on, (nrep - 3) / 2 of them, are
// summed along with their squares. After the last volume (repetition_count, clamped to
// 7..MAX_REPETITIONS) s_axis_tready drops while the solver works out the mean and
// mean / sample deviation in Q16.8 on a single shared add/subtract unit: shift-add
// multiplies, restoring divides and a bit-pair square root. The solver runs one step of the
// shared unit per cycle, and a voxel outside the mask goes straight to its result. The
// result then sits in an output register, and a new voxel's samples are taken while it
// waits. A zero deviation saturates tsnr and sets flat_series; a voxel outside the mask
// gives all zeros.
module voxel_temporal_snr #(
	parameter int MAX_REPETITIONS = vtsnr_pkg::MAX_REPETITIONS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [vtsnr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [vtsnr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [vtsnr_pkg::SAMPLE_BITS-1:0]      s_axis_tdata,  // [15:0] sample
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [2*vtsnr_pkg::OUT_BITS-1:0]       m_axis_tdata,  // [23:0] tsnr, [47:24] mean_value
	output logic [1:0]                             m_axis_tuser   // [0] in_mask, [1] flat_series
);

	localparam int NB   = vtsnr_pkg::count_bits(MAX_REPETITIONS);
	localparam int SW   = vtsnr_pkg::SAMPLE_BITS + NB;
	localparam int QW   = 2 * vtsnr_pkg::SAMPLE_BITS + NB;
	localparam int OUTW = vtsnr_pkg::OUT_BITS;

	logic [vtsnr_pkg::CUTOFF_BITS-1:0] cutoff_q;
	logic [vtsnr_pkg::RC_BITS-1:0]     rep_count_q;

	vtsnr_pkg::voxel_end_t vox;
	logic [SW-1:0]         sum;
	logic [QW-1:0]         sqsum;
	logic [NB-1:0]         count;
	logic                  take;

	logic                  res_valid;
	logic                  res_ready;
	logic [OUTW-1:0]       res_tsnr;
	logic [OUTW-1:0]       res_mean;
	vtsnr_pkg::res_flags_t res_flags;

	logic                  m_valid_q;
	logic [OUTW-1:0]       tsnr_q;
	logic [OUTW-1:0]       mean_q;
	vtsnr_pkg::res_flags_t flags_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q    <= '0;
			rep_count_q <= vtsnr_pkg::RC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vtsnr_pkg::REG_CUTOFF_LEVEL: cutoff_q <= cfg_data[vtsnr_pkg::CUTOFF_BITS-1:0];
				vtsnr_pkg::REG_REPETITION_COUNT: rep_count_q <= cfg_data[vtsnr_pkg::RC_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign take = s_axis_tvalid && s_axis_tready;

	vtsnr_accum #(
		.MAX_REPETITIONS(MAX_REPETITIONS)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.sample   (s_axis_tdata),
		.cutoff   (cutoff_q),
		.rep_count(rep_count_q),
		.vox      (vox),
		.sum      (sum),
		.sqsum    (sqsum),
		.count    (count)
	);

	vtsnr_solver #(
		.MAX_REPETITIONS(MAX_REPETITIONS)
	) u_solver (
		.clk      (clk),
		.arst_n   (arst_n),
		.vox      (vox),
		.sum      (sum),
		.sqsum    (sqsum),
		.count    (count),
		.ready    (s_axis_tready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_tsnr (res_tsnr),
		.res_mean (res_mean),
		.res_flags(res_flags)
	);

	// Output register: load when empty or being drained
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			tsnr_q  <= res_tsnr;
			mean_q  <= res_mean;
			flags_q <= res_flags;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {mean_q, tsnr_q};
	assign m_axis_tuser  = flags_q;

endmodule

/* design/vtsnr_addsub.sv */
// Shared add/subtract unit: every multiply, divide and root step runs through here
module vtsnr_addsub #(
	parameter int W = 8
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] y
);

	logic [W-1:0] b_eff;

	// Invert and carry in for subtraction
	assign b_eff = sub ? ~b : b;
	assign y     = a + b_eff + W'(sub);

endmodule

/* design/vtsnr_accum.sv */
// Per-voxel bookkeeping: volume index, mask decision, sum and sum of squares
module vtsnr_accum #(
	parameter int MAX_REPETITIONS = vtsnr_pkg::MAX_REPETITIONS_DEF,
	localparam int NB = vtsnr_pkg::count_bits(MAX_REPETITIONS),
	localparam int SW = vtsnr_pkg::SAMPLE_BITS + NB,
	localparam int QW = 2 * vtsnr_pkg::SAMPLE_BITS + NB
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [vtsnr_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic [vtsnr_pkg::CUTOFF_BITS-1:0]   cutoff,
	input  logic [vtsnr_pkg::RC_BITS-1:0]       rep_count,
	output vtsnr_pkg::voxel_end_t               vox,
	output logic [SW-1:0]                       sum,
	output logic [QW-1:0]                       sqsum,
	output logic [NB-1:0]                       count
);

	localparam int NTOP = vtsnr_pkg::nrep_top(MAX_REPETITIONS);
	localparam int IW   = $clog2(NTOP);
	localparam int RB   = vtsnr_pkg::RC_BITS;

	logic [IW-1:0] idx_q;
	logic          mask_q;
	logic [SW-1:0] sum_q;
	logic [QW-1:0] sqsum_q;
	logic [NB-1:0] cnt_q;

	logic [RB-1:0]                       nrep;
	logic [RB-1:0]                       span;
	logic [NB-1:0]                       n_tgt;
	logic                                last;
	logic                                acc_vol;
	logic [2*vtsnr_pkg::SAMPLE_BITS-1:0] square;
	logic                                mask_d;
	logic [SW-1:0]                       sum_d;
	logic [QW-1:0]                       sqsum_d;
	logic [NB-1:0]                       cnt_d;

	// Clamp the volume count and derive how many samples are taken
	always_comb begin
		if (rep_count < RB'(vtsnr_pkg::NREP_MIN)) begin
			nrep = RB'(vtsnr_pkg::NREP_MIN);
		end else if (rep_count > RB'(NTOP)) begin
			nrep = RB'(NTOP);
		end else begin
			nrep = rep_count;
		end
		span  = (nrep - RB'(vtsnr_pkg::FIRST_TAKEN_VOL)) >> 1;
		n_tgt = span[NB-1:0];
	end

	// Last volume of the voxel; odd volumes from the third on are taken
	assign last    = ((RB + 1)'(idx_q) + (RB + 1)'(1)) >= {1'b0, nrep};
	assign acc_vol = idx_q[0] && (idx_q != IW'(1)) && (cnt_q < n_tgt);
	assign square  = sample * sample;

	// Updated voxel state including the current sample
	always_comb begin
		mask_d  = mask_q;
		sum_d   = sum_q;
		sqsum_d = sqsum_q;
		cnt_d   = cnt_q;
		if (idx_q == '0) begin
			// The upper mask limit lies beyond any 16-bit sample
			mask_d = sample > cutoff;
		end else if (acc_vol) begin
			sum_d   = sum_q + SW'(sample);
			sqsum_d = sqsum_q + QW'(square);
			cnt_d   = cnt_q + NB'(1);
		end
	end

	// Hand the finished voxel to the solver
	assign vox.start   = take && last;
	assign vox.in_mask = mask_d;
	assign sum         = sum_d;
	assign sqsum       = sqsum_d;
	assign count       = cnt_d;

	// Advance or clear the voxel state on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			mask_q  <= 1'b0;
			sum_q   <= '0;
			sqsum_q <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			if (last) begin
				idx_q   <= '0;
				mask_q  <= 1'b0;
				sum_q   <= '0;
				sqsum_q <= '0;
				cnt_q   <= '0;
			end else begin
				idx_q   <= idx_q + IW'(1);
				mask_q  <= mask_d;
				sum_q   <= sum_d;
				sqsum_q <= sqsum_d;
				cnt_q   <= cnt_d;
			end
		end
	end

endmodule

/* design/vtsnr_solver.sv */
// End-of-voxel solver: mean and tSNR by shift-add multiply, restoring divide and
// digit-by-digit square root, all on one shared add/subtract unit
module vtsnr_solver #(
	parameter int MAX_REPETITIONS = vtsnr_pkg::MAX_REPETITIONS_DEF,
	localparam int NB = vtsnr_pkg::count_bits(MAX_REPETITIONS),
	localparam int SW = vtsnr_pkg::SAMPLE_BITS + NB,
	localparam int QW = 2 * vtsnr_pkg::SAMPLE_BITS + NB
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vtsnr_pkg::voxel_end_t            vox,
	input  logic [SW-1:0]                    sum,
	input  logic [QW-1:0]                    sqsum,
	input  logic [NB-1:0]                    count,
	output logic                             ready,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [vtsnr_pkg::OUT_BITS-1:0]   res_tsnr,
	output logic [vtsnr_pkg::OUT_BITS-1:0]   res_mean,
	output vtsnr_pkg::res_flags_t            res_flags
);

	localparam int OUTW  = vtsnr_pkg::OUT_BITS;
	localparam int FRAC  = vtsnr_pkg::FRAC_BITS;
	localparam int SHIFT = vtsnr_pkg::TSNR_SHIFT;
	localparam int PW    = 2 * SW;
	localparam int DENW  = NB + PW;
	localparam int RW    = DENW + 1;
	localparam int AW    = RW + 1;
	localparam int DVW   = DENW + SHIFT;
	localparam int MEANW = SW + FRAC;
	localparam int VW    = 2 * OUTW;
	localparam int CW    = $clog2(DVW + 1);

	vtsnr_pkg::solve_state_t state_q, state_d;

	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   s_q;
	logic [NB-1:0]   n_q;
	logic            mask_q;
	logic            flat_q;
	logic [PW-1:0]   x_q;
	logic [PW-1:0]   ss_q;
	logic [AW-1:0]   acc_q;
	logic [AW-1:0]   mcand_q;
	logic [SW-1:0]   mplier_q;
	logic [RW-1:0]   rem_q;
	logic [DENW-1:0] dsr_q;
	logic [DVW-1:0]  dvd_q;
	logic [OUTW-1:0] root_q;
	logic [OUTW-1:0] mean_q;
	logic [OUTW-1:0] tsnr_q;

	logic [AW-1:0]    alu_a;
	logic [AW-1:0]    alu_b;
	logic             alu_sub;
	logic [AW-1:0]    alu_y;
	logic             last;
	logic             take;
	logic [AW-1:0]    acc_nx;
	logic [RW-1:0]    div_sh;
	logic [RW-1:0]    sq_sh;
	logic [OUTW+1:0]  trial;
	logic [MEANW-1:0] quot_mean;
	logic [OUTW-1:0]  mean_sat;
	logic [DVW-1:0]   quot_full;
	logic             quot_over;
	logic [PW-1:0]    d_val;
	logic             flat_now;

	vtsnr_addsub #(
		.W(AW)
	) u_addsub (
		.a  (alu_a),
		.b  (alu_b),
		.sub(alu_sub),
		.y  (alu_y)
	);

	// Step helpers around the shared unit
	assign last      = cnt_q == CW'(1);
	assign take      = !alu_y[AW-1];
	assign acc_nx    = mplier_q[0] ? alu_y : acc_q;
	assign div_sh    = {rem_q[RW-2:0], dvd_q[DVW-1]};
	assign sq_sh     = {rem_q[RW-3:0], dvd_q[DVW-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign quot_mean = {dvd_q[MEANW-2:0], take};
	assign mean_sat  = (|quot_mean[MEANW-1:OUTW]) ? {OUTW{1'b1}} : quot_mean[OUTW-1:0];
	assign quot_full = {dvd_q[DVW-2:0], take};
	assign quot_over = |quot_full[DVW-1:VW];
	assign d_val     = alu_y[PW-1:0];
	assign flat_now  = (n_q < NB'(2)) || (d_val == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vtsnr_pkg::SV_IDLE: begin
				if (vox.start) begin
					state_d = vox.in_mask ? vtsnr_pkg::SV_MUL_NQ : vtsnr_pkg::SV_DONE;
				end
			end
			vtsnr_pkg::SV_MUL_NQ: begin
				if (last) state_d = vtsnr_pkg::SV_MUL_SS;
			end
			vtsnr_pkg::SV_MUL_SS: begin
				if (last) state_d = vtsnr_pkg::SV_SUB_D;
			end
			vtsnr_pkg::SV_SUB_D: begin
				state_d = (n_q == '0) ? vtsnr_pkg::SV_DONE : vtsnr_pkg::SV_DIV_MEAN;
			end
			vtsnr_pkg::SV_DIV_MEAN: begin
				if (last) state_d = flat_q ? vtsnr_pkg::SV_DONE : vtsnr_pkg::SV_MUL_DEN;
			end
			vtsnr_pkg::SV_MUL_DEN: begin
				if (last) state_d = vtsnr_pkg::SV_MUL_NUM;
			end
			vtsnr_pkg::SV_MUL_NUM: begin
				if (last) state_d = vtsnr_pkg::SV_DIV_TSNR;
			end
			vtsnr_pkg::SV_DIV_TSNR: begin
				if (last) state_d = quot_over ? vtsnr_pkg::SV_DONE : vtsnr_pkg::SV_SQRT;
			end
			vtsnr_pkg::SV_SQRT: begin
				if (last) state_d = vtsnr_pkg::SV_DONE;
			end
			vtsnr_pkg::SV_DONE: begin
				if (res_ready) state_d = vtsnr_pkg::SV_IDLE;
			end
			default: state_d = vtsnr_pkg::SV_IDLE;
		endcase
	end

	// Outputs: operand routing to the shared unit and handshake flags
	always_comb begin
		alu_a     = '0;
		alu_b     = '0;
		alu_sub   = 1'b0;
		ready     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			vtsnr_pkg::SV_IDLE: ready = 1'b1;
			vtsnr_pkg::SV_MUL_NQ, vtsnr_pkg::SV_MUL_SS,
			vtsnr_pkg::SV_MUL_DEN, vtsnr_pkg::SV_MUL_NUM: begin
				alu_a = acc_q;
				alu_b = mcand_q;
			end
			vtsnr_pkg::SV_SUB_D: begin
				alu_a   = AW'(x_q);
				alu_b   = AW'(ss_q);
				alu_sub = 1'b1;
			end
			vtsnr_pkg::SV_DIV_MEAN, vtsnr_pkg::SV_DIV_TSNR: begin
				alu_a   = AW'(div_sh);
				alu_b   = AW'(dsr_q);
				alu_sub = 1'b1;
			end
			vtsnr_pkg::SV_SQRT: begin
				alu_a   = AW'(sq_sh);
				alu_b   = AW'(trial);
				alu_sub = 1'b1;
			end
			vtsnr_pkg::SV_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtsnr_pkg::SV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers; each phase loads the operands of the next on its last step
	always_ff @(posedge clk) begin
		case (state_q)
			vtsnr_pkg::SV_IDLE: begin
				if (vox.start) begin
					s_q      <= sum;
					n_q      <= count;
					mask_q   <= vox.in_mask;
					flat_q   <= 1'b0;
					mean_q   <= '0;
					tsnr_q   <= '0;
					acc_q    <= '0;
					mcand_q  <= AW'(sqsum);
					mplier_q <= SW'(count);
					cnt_q    <= CW'(NB);
				end
			end
			vtsnr_pkg::SV_MUL_NQ: begin
				if (last) begin
					x_q      <= acc_nx[PW-1:0];
					acc_q    <= '0;
					mcand_q  <= AW'(s_q);
					mplier_q <= s_q;
					cnt_q    <= CW'(SW);
				end else begin
					acc_q    <= acc_nx;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - CW'(1);
				end
			end
			vtsnr_pkg::SV_MUL_SS: begin
				acc_q    <= acc_nx;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q - CW'(1);
				if (last) begin
					ss_q <= acc_nx[PW-1:0];
				end
			end
			vtsnr_pkg::SV_SUB_D: begin
				// Zero deviation or too few samples: saturate tSNR
				x_q    <= d_val;
				flat_q <= flat_now;
				tsnr_q <= flat_now ? {OUTW{1'b1}} : '0;
				rem_q  <= '0;
				dvd_q  <= {s_q, {FRAC{1'b0}}, {(DVW - MEANW){1'b0}}};
				dsr_q  <= DENW'(n_q);
				cnt_q  <= CW'(MEANW);
			end
			vtsnr_pkg::SV_DIV_MEAN: begin
				rem_q <= take ? alu_y[RW-1:0] : div_sh;
				dvd_q <= quot_full;
				if (last) begin
					mean_q   <= mean_sat;
					acc_q    <= '0;
					mcand_q  <= AW'(x_q);
					mplier_q <= SW'(n_q);
					cnt_q    <= CW'(NB);
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			vtsnr_pkg::SV_MUL_DEN: begin
				if (last) begin
					dsr_q    <= acc_nx[DENW-1:0];
					acc_q    <= '0;
					mcand_q  <= AW'(ss_q);
					mplier_q <= SW'(n_q - NB'(1));
					cnt_q    <= CW'(NB);
				end else begin
					acc_q    <= acc_nx;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - CW'(1);
				end
			end
			vtsnr_pkg::SV_MUL_NUM: begin
				acc_q    <= acc_nx;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				if (last) begin
					dvd_q <= {acc_nx[DENW-1:0], {SHIFT{1'b0}}};
					rem_q <= '0;
					cnt_q <= CW'(DVW);
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			vtsnr_pkg::SV_DIV_TSNR: begin
				if (last && !quot_over) begin
					dvd_q  <= {quot_full[VW-1:0], {(DVW - VW){1'b0}}};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CW'(OUTW);
				end else begin
					rem_q <= take ? alu_y[RW-1:0] : div_sh;
					dvd_q <= quot_full;
					cnt_q <= cnt_q - CW'(1);
				end
				if (last && quot_over) begin
					tsnr_q <= {OUTW{1'b1}};
				end
			end
			vtsnr_pkg::SV_SQRT: begin
				rem_q  <= take ? alu_y[RW-1:0] : sq_sh;
				root_q <= {root_q[OUTW-2:0], take};
				dvd_q  <= dvd_q << 2;
				cnt_q  <= cnt_q - CW'(1);
				if (last) begin
					tsnr_q <= {root_q[OUTW-2:0], take};
				end
			end
			default: ;
		endcase
	end

	assign res_tsnr              = tsnr_q;
	assign res_mean              = mean_q;
	assign res_flags.in_mask     = mask_q;
	assign res_flags.flat_series = flat_q;

	// A finished voxel always occupies the solver on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vox.start |=> state_q != vtsnr_pkg::SV_IDLE)
		else $error("solver idle after voxel start");

	// The root is only taken for an in-mask voxel with a nonzero deviation
	a_sqrt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vtsnr_pkg::SV_SQRT |-> mask_q && !flat_q)
		else $error("square root on flat or masked-out voxel");

	// Divisions never run with a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vtsnr_pkg::SV_DIV_MEAN || state_q == vtsnr_pkg::SV_DIV_TSNR)
		|-> dsr_q != '0)
		else $error("division by zero");

	// Masked-out voxels report all zeros
	a_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vtsnr_pkg::SV_DONE && !mask_q)
		|-> tsnr_q == '0 && mean_q == '0 && !flat_q)
		else $error("masked-out voxel with nonzero result");

endmodule
